[rtl/rotated_polygon_scanline_fill_unit_macros.svh]
// assertion macros for the arrow fill unit checker
`ifndef ROTATED_POLYGON_SCANLINE_FILL_UNIT_MACROS_SVH
`define ROTATED_POLYGON_SCANLINE_FILL_UNIT_MACROS_SVH
// same-cycle implication on clk, disabled in reset
`define RPSF_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("rpsf check failed");
// next-cycle implication on clk, disabled in reset
`define RPSF_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("rpsf check failed");
`endif

[rtl/rpsf_pkg.sv]
// shared types, constants and tables of the arrow fill unit
package rpsf_pkg;

	localparam int DEF_CANVAS_WIDTH  = 28;
	localparam int DEF_CANVAS_HEIGHT = 28;
	localparam int NVERT      = 7;
	localparam int BEARING_W  = 12;
	localparam int ROW_IDX_W  = 5;
	localparam int ROW_PIX_W  = 56;
	localparam int COORD_W    = 17;
	localparam int SINE_W     = 15;
	localparam int SINE_DEPTH = 1025;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH-1];

	typedef enum logic [3:0] {
		ST_IDLE, ST_SIN, ST_COS, ST_CAPC, ST_ROT, ST_ROW, ST_ERD, ST_ETEST,
		ST_DINIT, ST_DIV, ST_INS, ST_FILL, ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_bearing;
		logic rom_sin;
		logic rom_cos;
		logic cap_sin;
		logic cap_cos;
		logic rot_step;
		logic row_start;
		logic edge_rd;
		logic edge_test;
		logic div_init;
		logic div_step;
		logic insert;
		logic edge_next;
		logic fill_step;
		logic emit;
		logic row_next;
	} dp_cmd_t;

	typedef struct packed {
		logic rot_last;
		logic crossing;
		logic div_done;
		logic edge_last;
		logic fill_more;
		logic row_last;
		logic out_free;
	} dp_status_t;

	// shift and subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned dv);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= dv) begin
				r = r - dv;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [SINE_W-1:0] quarter_sine(input int k);
		longint unsigned x, x2, t, dv;
		longint s;
		x = (longint'(k) * PI_Q30) >> 11;
		x2 = (x * x) >> 30;
		t = x;
		s = longint'(x);
		for (int d = 2; d <= 14; d += 2) begin
			dv = longint'(d * (d + 1));
			t = udiv64((t * x2) >> 30, dv);
			if (((d >> 1) & 1) != 0) s = s - longint'(t);
			else s = s + longint'(t);
		end
		if (s < 0) s = 0;
		s = (s + 32768) >>> 16;
		if (s > 16384) s = 16384;
		return SINE_W'(s);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int k = 0; k < SINE_DEPTH; k++) r[k] = quarter_sine(k);
		return r;
	endfunction

	function automatic logic signed [4:0] vert_x(input logic [2:0] i);
		logic signed [4:0] v;
		case (i)
			3'd0: v = 5'sd0;
			3'd1: v = -5'sd10;
			3'd2: v = -5'sd4;
			3'd3: v = -5'sd4;
			3'd4: v = 5'sd4;
			3'd5: v = 5'sd4;
			3'd6: v = 5'sd10;
			default: v = 5'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [4:0] vert_y(input logic [2:0] i);
		logic signed [4:0] v;
		case (i)
			3'd0: v = -5'sd12;
			3'd1: v = -5'sd2;
			3'd2: v = -5'sd2;
			3'd3: v = 5'sd12;
			3'd4: v = 5'sd12;
			3'd5: v = -5'sd2;
			3'd6: v = -5'sd2;
			default: v = 5'sd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/rpsf_in_if.sv]
// bearing input channel
interface rpsf_in_if;
	logic valid;
	logic ready;
	logic [rpsf_pkg::BEARING_W-1:0] bearing;
	modport source (output valid, output bearing, input ready);
	modport sink (input valid, input bearing, output ready);
endinterface

[rtl/rpsf_out_if.sv]
// row result channel
interface rpsf_out_if;
	logic valid;
	logic ready;
	logic [rpsf_pkg::ROW_IDX_W-1:0] row_index;
	logic [rpsf_pkg::ROW_PIX_W-1:0] row_pixels;
	logic last_row;
	modport source (output valid, output row_index, output row_pixels, output last_row,
		input ready);
	modport sink (input valid, input row_index, input row_pixels, input last_row,
		output ready);
endinterface

[rtl/rpsf_ctrl.sv]
// controller state machine of the arrow fill unit
module rpsf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rpsf_pkg::dp_status_t  status,
	output rpsf_pkg::dp_cmd_t     cmd
);
	import rpsf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_bearing = 1'b1;
					state_d = ST_SIN;
				end
			end
			ST_SIN: begin
				cmd.rom_sin = 1'b1;
				state_d = ST_COS;
			end
			ST_COS: begin
				cmd.rom_cos = 1'b1;
				cmd.cap_sin = 1'b1;
				state_d = ST_CAPC;
			end
			ST_CAPC: begin
				cmd.cap_cos = 1'b1;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (status.rot_last) state_d = ST_ROW;
			end
			ST_ROW: begin
				cmd.row_start = 1'b1;
				state_d = ST_ERD;
			end
			ST_ERD: begin
				cmd.edge_rd = 1'b1;
				state_d = ST_ETEST;
			end
			ST_ETEST: begin
				cmd.edge_test = 1'b1;
				if (status.crossing) begin
					state_d = ST_DINIT;
				end else if (status.edge_last) begin
					state_d = ST_FILL;
				end else begin
					cmd.edge_next = 1'b1;
					state_d = ST_ERD;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = ST_INS;
			end
			ST_INS: begin
				cmd.insert = 1'b1;
				if (status.edge_last) begin
					state_d = ST_FILL;
				end else begin
					cmd.edge_next = 1'b1;
					state_d = ST_ERD;
				end
			end
			ST_FILL: begin
				if (status.fill_more) cmd.fill_step = 1'b1;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.row_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.row_next = 1'b1;
						state_d = ST_ROW;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/rpsf_datapath.sv]
// datapath: sine table, vertex rotation, edge crossings, divider, sorted list, row fill
module rpsf_datapath #(
	parameter int CANVAS_WIDTH  = rpsf_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = rpsf_pkg::DEF_CANVAS_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rpsf_pkg::BEARING_W-1:0]    bearing,
	input  rpsf_pkg::dp_cmd_t                 cmd,
	output rpsf_pkg::dp_status_t              status,
	rpsf_out_if.source                        rows
);
	import rpsf_pkg::*;

	localparam int CW    = COORD_W;
	localparam int PW    = 2 * CW + 2;
	localparam int MAG_W = PW - 1;
	localparam int DCW   = $clog2(MAG_W);
	localparam int RW    = $clog2(CANVAS_HEIGHT);
	localparam int PIX_W = 2 * CANVAS_WIDTH;
	localparam logic signed [23:0] CX = 24'((CANVAS_WIDTH - 1) * 128);
	localparam logic signed [23:0] CY = 24'((CANVAS_HEIGHT - 1) * 128);
	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [BEARING_W-1:0] bearing_q;
	logic [SINE_W-1:0]    rom_q;
	logic                 rom_neg_q;
	logic signed [15:0]   sin_q, cos_q, rom_val;
	logic [BEARING_W-1:0] phase;
	logic [10:0]          rom_addr;

	logic [2:0]           vcnt_q, edge_q, edge_nxt;
	logic signed [CW-1:0] rx_mem [NVERT];
	logic signed [CW-1:0] ry_mem [NVERT];
	logic signed [23:0]   sum_x, sum_y;
	logic signed [CW-1:0] rx_w, ry_w;

	logic [RW-1:0]        row_q;
	logic signed [CW-1:0] fy;
	logic signed [CW-1:0] x0_q, x1_q, y0_q, y1_q;
	logic signed [CW:0]   dy, dx, den;
	logic signed [PW-1:0] prod_q;
	logic signed [CW:0]   den_q;

	logic [MAG_W-1:0]     q_sh_q;
	logic [CW:0]          rem_q, den_mag_q;
	logic                 neg_q;
	logic [DCW-1:0]       dcnt_q;
	logic [CW+1:0]        trial;
	logic                 qbit;
	logic [MAG_W-1:0]     q_adj;
	logic signed [MAG_W:0] quot;
	logic signed [CW-1:0] xc;

	logic signed [CW-1:0] cl_q [NVERT];
	logic [2:0]           nx_q;
	logic [NVERT-1:0]     le;

	logic [CANVAS_WIDTH-1:0] pix_q;
	logic signed [CW:0]   span_s, span_e;
	logic [PIX_W-1:0]     pix2;
	logic [PIX_W+ROW_PIX_W-1:0] pix_ext;
	logic [RW+ROW_IDX_W-1:0]    row_ext;
	logic                 out_valid_q;

	// sine table read with quadrant fold
	assign phase    = cmd.rom_cos ? bearing_q + BEARING_W'(1024) : bearing_q;
	assign rom_addr = phase[10] ? 11'(11'd1024 - {1'b0, phase[9:0]}) : {1'b0, phase[9:0]};
	assign rom_val  = rom_neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

	always_ff @(posedge clk) begin
		if (cmd.load_bearing) bearing_q <= bearing;
		rom_q     <= SINE_ROM[rom_addr];
		rom_neg_q <= phase[11];
		if (cmd.cap_sin) sin_q <= rom_val;
		if (cmd.cap_cos) cos_q <= rom_val;
	end

	// vertex rotation, one vertex per cycle
	assign sum_x = 24'(vert_x(vcnt_q)) * 24'(cos_q) - 24'(vert_y(vcnt_q)) * 24'(sin_q);
	assign sum_y = 24'(vert_x(vcnt_q)) * 24'(sin_q) + 24'(vert_y(vcnt_q)) * 24'(cos_q);
	assign rx_w  = CW'(CX + ((sum_x + 24'sd32) >>> 6));
	assign ry_w  = CW'(CY + ((sum_y + 24'sd32) >>> 6));

	assign edge_nxt = (edge_q == 3'(NVERT - 1)) ? 3'd0 : edge_q + 3'd1;

	always_ff @(posedge clk) begin
		if (cmd.rot_step) begin
			rx_mem[vcnt_q] <= rx_w;
			ry_mem[vcnt_q] <= ry_w;
		end
		if (cmd.edge_rd) begin
			x0_q <= rx_mem[edge_q];
			x1_q <= rx_mem[edge_nxt];
			y0_q <= ry_mem[edge_q];
			y1_q <= ry_mem[edge_nxt];
		end
	end

	// edge test and product
	assign fy  = $signed(CW'({row_q, 8'h80}));
	assign dy  = (CW+1)'(fy) - (CW+1)'(y0_q);
	assign dx  = (CW+1)'(x1_q) - (CW+1)'(x0_q);
	assign den = (CW+1)'(y1_q) - (CW+1)'(y0_q);

	always_ff @(posedge clk) begin
		if (cmd.edge_test) begin
			prod_q <= PW'(dy) * PW'(dx);
			den_q  <= den;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, q_sh_q[MAG_W-1]};
	assign qbit  = trial >= {1'b0, den_mag_q};
	assign q_adj = q_sh_q + MAG_W'(neg_q && (rem_q != '0));
	assign quot  = neg_q ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});
	assign xc    = CW'((MAG_W+1)'(x0_q) + quot);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			q_sh_q    <= prod_q[PW-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
			den_mag_q <= den_q[CW] ? (CW+1)'(-den_q) : (CW+1)'(den_q);
			neg_q     <= prod_q[PW-1] ^ den_q[CW];
			rem_q     <= '0;
		end else if (cmd.div_step) begin
			q_sh_q <= {q_sh_q[MAG_W-2:0], qbit};
			rem_q  <= qbit ? (CW+1)'(trial - {1'b0, den_mag_q}) : trial[CW:0];
		end
	end

	// sorted crossing list, insert on arrival, drained two at a time by fill
	always_comb begin
		for (int k = 0; k < NVERT; k++) le[k] = (3'(k) < nx_q) && (cl_q[k] <= xc);
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int k = 0; k < NVERT; k++) begin
				if (!le[k]) begin
					if (k == 0) cl_q[k] <= xc;
					else if (le[(k == 0) ? 0 : k-1]) cl_q[k] <= xc;
					else cl_q[k] <= cl_q[(k == 0) ? 0 : k-1];
				end
			end
		end else if (cmd.fill_step) begin
			for (int k = 0; k + 2 < NVERT; k++) cl_q[k] <= cl_q[k+2];
		end
	end

	assign span_s = ((CW+1)'(cl_q[0]) + (CW+1)'(128)) >>> 8;
	assign span_e = ((CW+1)'(cl_q[1]) + (CW+1)'(128)) >>> 8;

	always_ff @(posedge clk) begin
		if (cmd.row_start) begin
			pix_q <= '0;
		end else if (cmd.fill_step) begin
			for (int x = 0; x < CANVAS_WIDTH; x++) begin
				if ($signed((CW+1)'(x)) >= span_s && $signed((CW+1)'(x)) < span_e)
					pix_q[x] <= 1'b1;
			end
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			edge_q <= '0;
			row_q  <= '0;
			nx_q   <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load_bearing) begin
				vcnt_q <= '0;
				row_q  <= '0;
			end else begin
				if (cmd.rot_step) vcnt_q <= vcnt_q + 3'd1;
				if (cmd.row_next) row_q <= row_q + RW'(1);
			end
			if (cmd.row_start) edge_q <= '0;
			else if (cmd.edge_next) edge_q <= edge_nxt;
			if (cmd.row_start) nx_q <= '0;
			else if (cmd.insert) nx_q <= nx_q + 3'd1;
			else if (cmd.fill_step) nx_q <= nx_q - 3'd2;
			if (cmd.div_init) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	// output register
	always_comb begin
		for (int x = 0; x < CANVAS_WIDTH; x++) pix2[2*(CANVAS_WIDTH-1-x) +: 2] = {2{pix_q[x]}};
	end
	assign pix_ext = {{ROW_PIX_W{1'b0}}, pix2};
	assign row_ext = {{ROW_IDX_W{1'b0}}, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rows.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rows.row_index  <= row_ext[ROW_IDX_W-1:0];
			rows.row_pixels <= pix_ext[ROW_PIX_W-1:0];
			rows.last_row   <= (row_q == RW'(CANVAS_HEIGHT - 1));
		end
	end

	assign rows.valid = out_valid_q;

	assign status.rot_last  = (vcnt_q == 3'(NVERT - 1));
	assign status.crossing  = ((y0_q <= fy) && (y1_q > fy)) || ((y1_q <= fy) && (y0_q > fy));
	assign status.div_done  = (dcnt_q == DCW'(MAG_W - 1));
	assign status.edge_last = (edge_q == 3'(NVERT - 1));
	assign status.fill_more = (nx_q >= 3'd2);
	assign status.row_last  = (row_q == RW'(CANVAS_HEIGHT - 1));
	assign status.out_free  = !out_valid_q || rows.ready;

endmodule

[rtl/rotated_polygon_scanline_fill_unit.sv]
// top level of the rotated arrow scanline fill unit
// usage:
// - cmd takes one 12-bit bearing per transfer; cmd.ready is high only while
//   the unit is idle between images
// - rows returns CANVAS_HEIGHT transfers per bearing, top row first, each
//   with the row number, 2 bits per pixel (pixel 0 in the top bits, 3 filled)
//   and last_row set on the bottom row
// - setup after the bearing transfer: sine table reads and then the rotation,
//   one vertex per cycle over the 7 vertices
// - per row: a row start, then a read and a test for each edge of the arrow; each
//   crossing adds the bit-serial divider and an insert into the sorted list;
//   the fill then draws one span per cycle, and the row is loaded into the
//   output register
// - a finished row sits in the output register while the next row is being
//   computed; the unit waits only if that row is still untaken
// - a stall on rows holds valid and payload until the transfer
// - reset clears the state machine, counters and output valid; the unit
//   comes up idle and ready for a bearing
module rotated_polygon_scanline_fill_unit #(
	parameter int CANVAS_WIDTH  = rpsf_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = rpsf_pkg::DEF_CANVAS_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	rpsf_in_if.sink     cmd,
	rpsf_out_if.source  rows
);
	import rpsf_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	rpsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	rpsf_datapath #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.bearing (cmd.bearing),
		.cmd     (dp_cmd),
		.status  (dp_status),
		.rows    (rows)
	);

endmodule

[rtl/rpsf_checker.sv]
// port-level checker of the arrow fill unit and its bind
`include "rotated_polygon_scanline_fill_unit_macros.svh"
module rpsf_checker #(
	parameter int CANVAS_HEIGHT = rpsf_pkg::DEF_CANVAS_HEIGHT
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cmd_valid,
	input logic                             cmd_ready,
	input logic                             rows_valid,
	input logic                             rows_ready,
	input logic [rpsf_pkg::ROW_IDX_W-1:0]   rows_row_index,
	input logic                             rows_last_row
);
	import rpsf_pkg::*;

	localparam logic [ROW_IDX_W-1:0] LAST_IDX = ROW_IDX_W'((CANVAS_HEIGHT - 1) % 32);

	// no second bearing while an image is in work
	`RPSF_ASSERT_NXT(a_ready_drops, cmd_valid && cmd_ready, !cmd_ready)
	// the bottom row carries the last row number
	`RPSF_ASSERT_IMP(a_last_index, rows_valid && rows_last_row, rows_row_index == LAST_IDX)
	// a stalled row holds
	`RPSF_ASSERT_NXT(a_rows_hold, rows_valid && !rows_ready,
		rows_valid && $stable(rows_row_index) && $stable(rows_last_row))

endmodule

bind rotated_polygon_scanline_fill_unit rpsf_checker #(
	.CANVAS_HEIGHT (CANVAS_HEIGHT)
) u_rpsf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rows_valid     (rows.valid),
	.rows_ready     (rows.ready),
	.rows_row_index (rows.row_index),
	.rows_last_row  (rows.last_row)
);
